// ===== rtl/core/hcfp_pkg.sv =====
// ----------------------------------------------------------------------------
// Host command frame parser package
// Shared payload types, stage codes and framing byte constants.
// ----------------------------------------------------------------------------
`default_nettype none

package hcfp_pkg;

  // Parser stage codes.
  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_CMD   = 2'd1,
    ST_PARAM = 2'd2
  } stage_e;

  // Framing bytes.
  localparam logic [7:0] BYTE_START   = 8'h21;
  localparam logic [7:0] BYTE_SEP     = 8'h23;
  localparam logic [7:0] BYTE_UPPER_A = 8'h41;
  localparam logic [7:0] BYTE_UPPER_Z = 8'h5A;
  localparam logic [7:0] BYTE_CR      = 8'h0D;
  localparam logic [7:0] BYTE_LF      = 8'h0A;

  // Width of one character and of the packed text fields.
  localparam int unsigned CharW    = 8;
  localparam int unsigned TextChars = 6;
  localparam int unsigned TextW    = CharW * TextChars;
  localparam int unsigned LenW     = 3;

  // Input word: a received byte or a consume request.
  typedef struct packed {
    logic       func;
    logic [7:0] data_byte;
  } in_word_t;

  // Result word: parser status after the input word.
  typedef struct packed {
    logic              pending;
    logic [1:0]        stage;
    logic [LenW-1:0]   cmd_len;
    logic [TextW-1:0]  cmd_text;
    logic [LenW-1:0]   param_len;
    logic [TextW-1:0]  param_text;
  } out_word_t;

endpackage

`default_nettype wire

// ===== rtl/core/host_command_frame_parser_top.sv =====
// A result word is registered and appears on the output in the cycle after its input word is accepted.
// Throughput: one word per cycle while out_ready_i holds; the parser state is updated in the same cycle as the
// output register is loaded, so consecutive words follow with no gap.
// The output register lets a new word in while the last result waits, when it is taken.
// Reset clears the stage to idle, the pending flag, both buffers, counts and output valid.
// ----------------------------------------------------------------------------
// Host command frame parser top level
// Parses '!' CMD '#' PARAM CR/LF frames and reports parser status per word.
// ----------------------------------------------------------------------------
`default_nettype none

module host_command_frame_parser_top #(
  parameter int unsigned CMD_CHARS   = 6,
  parameter int unsigned PARAM_CHARS = 6
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire hcfp_pkg::in_word_t in_data_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output hcfp_pkg::out_word_t     out_data_o
);

  localparam int unsigned CmdCntW   = $clog2(CMD_CHARS + 1);
  localparam int unsigned ParamCntW = $clog2(PARAM_CHARS + 1);
  localparam int unsigned CmdPack   = (CMD_CHARS < hcfp_pkg::TextChars) ?
                                      CMD_CHARS : hcfp_pkg::TextChars;
  localparam int unsigned ParamPack = (PARAM_CHARS < hcfp_pkg::TextChars) ?
                                      PARAM_CHARS : hcfp_pkg::TextChars;

  hcfp_pkg::stage_e                  stage_q, stage_d;
  logic                              pending_q, pending_d;
  logic [CMD_CHARS-1:0][7:0]         cmd_store_q, cmd_store_d;
  logic [PARAM_CHARS-1:0][7:0]       param_store_q, param_store_d;
  logic [CmdCntW-1:0]                cmd_count_q, cmd_count_d;
  logic [ParamCntW-1:0]              param_count_q, param_count_d;
  logic                              out_valid_q;
  hcfp_pkg::out_word_t               out_data_q, out_data_d;
  logic                              in_fire;
  logic [7:0]                        b;
  logic                              is_upper;
  logic                              is_term;

  // Accept whenever the output register is empty or being emptied.
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  assign b        = in_data_i.data_byte;
  assign is_upper = (b >= hcfp_pkg::BYTE_UPPER_A) && (b <= hcfp_pkg::BYTE_UPPER_Z);
  assign is_term  = (b == hcfp_pkg::BYTE_CR) || (b == hcfp_pkg::BYTE_LF);

  // Next parser state for the incoming word.
  always_comb begin
    stage_d       = stage_q;
    pending_d     = pending_q;
    cmd_store_d   = cmd_store_q;
    param_store_d = param_store_q;
    cmd_count_d   = cmd_count_q;
    param_count_d = param_count_q;
    if (in_data_i.func) begin
      pending_d = 1'b0;
    end else begin
      unique case (stage_q)
        hcfp_pkg::ST_CMD: begin
          if (is_upper) begin
            if (cmd_count_q < CmdCntW'(CMD_CHARS)) begin
              for (int i = 0; i < CMD_CHARS; i++) begin
                if (cmd_count_q == CmdCntW'(i)) begin
                  cmd_store_d[i] = b;
                end
              end
              cmd_count_d = cmd_count_q + CmdCntW'(1);
            end
          end else if (b == hcfp_pkg::BYTE_SEP) begin
            stage_d = hcfp_pkg::ST_PARAM;
          end else begin
            stage_d = hcfp_pkg::ST_IDLE;
          end
        end
        hcfp_pkg::ST_PARAM: begin
          if (is_term) begin
            pending_d = 1'b1;
            stage_d   = hcfp_pkg::ST_IDLE;
          end else if (param_count_q < ParamCntW'(PARAM_CHARS)) begin
            for (int i = 0; i < PARAM_CHARS; i++) begin
              if (param_count_q == ParamCntW'(i)) begin
                param_store_d[i] = b;
              end
            end
            param_count_d = param_count_q + ParamCntW'(1);
          end
        end
        default: begin
          // Idle, and the unused code which behaves as idle.
          stage_d = hcfp_pkg::ST_IDLE;
          if ((b == hcfp_pkg::BYTE_START) && !pending_q) begin
            stage_d       = hcfp_pkg::ST_CMD;
            cmd_store_d   = '0;
            param_store_d = '0;
            cmd_count_d   = '0;
            param_count_d = '0;
          end
        end
      endcase
    end
  end

  // Pack the updated state into the result word. Bytes past the count are zero.
  always_comb begin
    out_data_d            = '0;
    out_data_d.pending    = pending_d;
    out_data_d.stage      = stage_d;
    out_data_d.cmd_len    = hcfp_pkg::LenW'(cmd_count_d);
    out_data_d.param_len  = hcfp_pkg::LenW'(param_count_d);
    for (int i = 0; i < CmdPack; i++) begin
      out_data_d.cmd_text[i*8 +: 8] = cmd_store_d[i];
    end
    for (int i = 0; i < ParamPack; i++) begin
      out_data_d.param_text[i*8 +: 8] = param_store_d[i];
    end
  end

  // Parser state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q       <= hcfp_pkg::ST_IDLE;
      pending_q     <= 1'b0;
      cmd_store_q   <= '0;
      param_store_q <= '0;
      cmd_count_q   <= '0;
      param_count_q <= '0;
    end else if (in_fire) begin
      stage_q       <= stage_d;
      pending_q     <= pending_d;
      cmd_store_q   <= cmd_store_d;
      param_store_q <= param_store_d;
      cmd_count_q   <= cmd_count_d;
      param_count_q <= param_count_d;
    end
  end

  // Output register valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_data_q <= out_data_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // The command count never passes the buffer size.
  a_cmd_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_count_q <= CmdCntW'(CMD_CHARS))
    else $error("command count exceeds buffer size");

  // The parameter count never passes the buffer size.
  a_param_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    param_count_q <= ParamCntW'(PARAM_CHARS))
    else $error("parameter count exceeds buffer size");

  // A frame can only complete from the parameter stage.
  a_pending_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(pending_q) |-> $past(stage_q == hcfp_pkg::ST_PARAM))
    else $error("pending set outside the parameter stage");

  // While a command is pending no new frame may be started.
  a_pending_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q |-> (stage_q == hcfp_pkg::ST_IDLE))
    else $error("parser left idle while a command is pending");

  // An accepted word always produces a result word in the next cycle.
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> out_valid_o)
    else $error("accepted word produced no result");

endmodule

`default_nettype wire
